[hdl/assert_macros.svh]
// Assertion macros used by the percentile select core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PSEL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSEL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/psel_pkg.sv]
// Shared types and constants of the percentile select block.
`default_nettype none

package psel_pkg;

   // Operation codes of a request.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Percent scale and the rounding offset added before dividing by it.
   localparam int unsigned PCT_SCALE = 100;
   localparam int unsigned PCT_HALF  = PCT_SCALE / 2;

   localparam int unsigned PERCENT_W = 7;
   localparam int unsigned VALUE_W   = 16;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [VALUE_W-1:0]   sample;
      logic [PERCENT_W-1:0] percent;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
   } rsp_type;

   // Status of the rank divider as seen by the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hdl/psel_cell.sv]
// One cell of the sorted insertion chain: holds one sample at a fixed rank.
`default_nettype none

module psel_cell #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned CNT_W = 9,
   parameter int unsigned INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             load_en,
   input  wire logic [WIDTH-1:0] new_sample,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             prev_gt,
   input  wire logic [WIDTH-1:0] prev_value,
   output logic                  gt,
   output logic [WIDTH-1:0]      value
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;
   logic             occupied;

   // The cell holds a live sample when its rank lies below the fill count.
   assign occupied = (count > CNT_W'(INDEX));

   // Strictly greater, so an equal sample lands after the ones already held.
   assign gt    = occupied && (value_ff > new_sample);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt || !occupied) begin
            value_in = new_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

[hdl/psel_rank_div.sv]
// Reciprocal multiplier that turns count*p+50 into a rank by dividing by 100.
`default_nettype none

module psel_rank_div #(
   parameter int unsigned CNT_W = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CNT_W+6:0]     dividend,
   output psel_pkg::div_status_type  status,
   output logic [CNT_W:0]            quotient
);

   localparam int unsigned N_W = CNT_W + 7;
   localparam int unsigned Q_W = CNT_W + 1;

   // The reciprocal is ceil(2^SH / 100). Its excess over the exact value is
   // below 100, so with SH = N_W + 7 the product error stays under 2^N_W
   // (1/128 of a quotient step) for every N_W-bit dividend; the quotient is exact.
   localparam int unsigned SH  = N_W + 7;
   localparam int unsigned M_W = SH - 5;
   localparam int unsigned P_W = N_W + M_W;
   localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << SH) + 64'(psel_pkg::PCT_SCALE) - 64'd1) /
           64'(psel_pkg::PCT_SCALE));

   logic [N_W-1:0] dvd_ff, dvd_in;
   logic [Q_W-1:0] quot_ff, quot_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [P_W-1:0] product;

   // The dividend is registered first so the rank product and this multiply
   // never sit in the same cycle.
   assign product = P_W'(dvd_ff) * P_W'(RECIP);

   always_comb begin
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      busy_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = product[SH +: Q_W];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

`default_nettype wire

[hdl/percentile_select_core.sv]
// Top level of the nearest-rank percentile select block.
// The block keeps up to MAX_SAMPLES duration samples in ascending order in a
// chain of cells, one sample per cell. A load transfer inserts its sample as
// the transfer is taken: every cell compares the new sample with its own and
// either keeps its value, takes the new sample, or takes its lower neighbor's
// value, so the set is always sorted and a query is a direct read. Equal
// samples are placed after those already held. A clear transfer empties the
// set and returns no result; opcode 3 is ignored and returns nothing. A query
// with percent p returns the sample at rank round(count*p/100), clamped to
// count-1; on an empty set it returns zero with the empty status. A load on a
// full set drops the sample and returns the full status. Items are handled
// one at a time: a clear or an ignored opcode is done when it is accepted,
// a load or a query on an empty set then passes to the result stage, and a
// query on a filled set goes through the divider by 100, which registers
// count*p+50 and multiplies it by the reciprocal of 100, then a stage to
// clamp the rank, one to read the cell and one to hand the result to the
// output register. A finished result sits in the output register, and the
// block goes on accepting request transfers while it waits there; the next
// item that produces a result then holds in its last stage until the output
// register frees, which adds the result side's stall cycles to its time.
`default_nettype none
`include "assert_macros.svh"

module percentile_select_core #(
   parameter int unsigned MAX_SAMPLES = 256,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire psel_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output psel_pkg::rsp_type       rsp_data
);

   // Fill count width holds MAX_SAMPLES itself; the cell index needs one less
   // state. The divider works on count*p+50 and yields a rank below 2*count.
   localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
   localparam int unsigned N_W   = CNT_W + 7;
   localparam int unsigned Q_W   = CNT_W + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_CLAMP = 5'b00100,
      S_READ  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [psel_pkg::VALUE_W-1:0]   pend_value_ff, pend_value_in;
   logic [1:0]                     pend_status_ff, pend_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   psel_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           req_xfer;
   logic                           rsp_xfer;
   logic                           slot_free;
   logic                           set_full;
   logic                           set_empty;
   logic                           load_en;
   logic                           div_start;
   logic [N_W-1:0]                 dividend;
   logic [Q_W-1:0]                 quotient;
   logic [CNT_W-1:0]               last_rank;
   psel_pkg::div_status_type       div_status;
   logic [SAMPLE_BITS-1:0]         new_sample;

   logic [SAMPLE_BITS-1:0]         cell_value [MAX_SAMPLES];
   logic                           cell_gt    [MAX_SAMPLES];

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign set_full  = (count_ff == CNT_W'(MAX_SAMPLES));
   assign set_empty = (count_ff == '0);
   assign req_stall = (state_ff != S_IDLE);

   assign new_sample = SAMPLE_BITS'(req_data.sample);
   assign load_en    = req_xfer && (req_data.opcode == psel_pkg::OP_LOAD) && !set_full;
   assign div_start  = req_xfer && (req_data.opcode == psel_pkg::OP_QUERY) && !set_empty;

   // Rank numerator with half-up rounding: count * p + 50.
   assign dividend = N_W'(count_ff) * N_W'(req_data.percent) + N_W'(psel_pkg::PCT_HALF);
   assign last_rank = count_ff - CNT_W'(1);

   // The sorted insertion chain. Cell 0 has no lower neighbor.
   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      if (i == 0) begin : g_first
         psel_cell #(
            .WIDTH (SAMPLE_BITS),
            .CNT_W (CNT_W),
            .INDEX (i)
         ) u_cell (
            .clock      (clock),
            .load_en    (load_en),
            .new_sample (new_sample),
            .count      (count_ff),
            .prev_gt    (1'b0),
            .prev_value ({SAMPLE_BITS{1'b0}}),
            .gt         (cell_gt[i]),
            .value      (cell_value[i])
         );
      end else begin : g_next
         psel_cell #(
            .WIDTH (SAMPLE_BITS),
            .CNT_W (CNT_W),
            .INDEX (i)
         ) u_cell (
            .clock      (clock),
            .load_en    (load_en),
            .new_sample (new_sample),
            .count      (count_ff),
            .prev_gt    (cell_gt[i-1]),
            .prev_value (cell_value[i-1]),
            .gt         (cell_gt[i]),
            .value      (cell_value[i])
         );
      end
   end

   psel_rank_div #(
      .CNT_W (CNT_W)
   ) u_rank_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      // The consumer took the waiting result.
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_data.opcode)
                  psel_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  psel_pkg::OP_LOAD: begin
                     pend_value_in = '0;
                     if (set_full) begin
                        pend_status_in = psel_pkg::ST_FULL;
                     end else begin
                        pend_status_in = psel_pkg::ST_OK;
                        count_in       = count_ff + CNT_W'(1);
                     end
                     state_in = S_DONE;
                  end
                  psel_pkg::OP_QUERY: begin
                     if (set_empty) begin
                        pend_value_in  = '0;
                        pend_status_in = psel_pkg::ST_EMPTY;
                        state_in       = S_DONE;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            // A rank at or past the end of the set selects the largest sample.
            if (quotient >= Q_W'(count_ff)) begin
               idx_in = last_rank[IDX_W-1:0];
            end else begin
               idx_in = quotient[IDX_W-1:0];
            end
            state_in = S_READ;
         end
         S_READ: begin
            pend_value_in  = psel_pkg::VALUE_W'(cell_value[idx_ff]);
            pend_status_in = psel_pkg::ST_OK;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.value  = pend_value_ff;
               rsp_data_in.status = pend_status_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never passes the capacity.
   `PSEL_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_SAMPLES), "sample count past capacity")

   // The divider reports completion only while the controller waits for it.
   `PSEL_ASSERT(a_div_done_state, div_status.done |-> (state_ff == S_DIV), "divider done outside DIV")

   // The clamped rank always points at a live sample.
   `PSEL_ASSERT(a_idx_live, (state_ff == S_READ) |-> (CNT_W'(idx_ff) < count_ff), "read rank not below count")

   // A new result appears only when leaving the result stage.
   `PSEL_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "result without DONE")

   // An accepted load on a set with room grows the set by exactly one.
   `PSEL_ASSERT(a_load_grows, load_en |=> (count_ff == $past(count_ff) + CNT_W'(1)), "load did not grow count")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the percentile select core: directed table, random sets, idling.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // The one opcode the package does not name; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Capacity of the sample set, passed down to the block so both sides agree.
   localparam int unsigned SET_DEPTH = 256;

   // A query is the slowest item. The tail wait covers it with margin, and the
   // watchdog is far beyond any run of cycles without a transfer that random
   // stalls and gaps can produce.
   localparam int unsigned TAIL_CYCLES = 40;
   localparam int unsigned QUIET_LIMIT = 2000;

   // One row of the directed table. Where typed is set, the expected result is
   // the one written in the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [1:0]                     opcode;
      logic [psel_pkg::VALUE_W-1:0]   sample;
      logic [psel_pkg::PERCENT_W-1:0] percent;
      bit                             typed;
      logic [psel_pkg::VALUE_W-1:0]   want_value;
      logic [1:0]                     want_status;
   } stim_row_type;

   localparam int N_ROWS = 23;

   // Rows walk through an empty query, extreme and equal samples, the percent
   // extremes (zero, one, 99 and the top of the field), clamping past the end,
   // an exact half that rounds up, the ignored opcode and clear.
   stim_row_type directed_rows [N_ROWS] = '{
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd50,  1'b1, 16'h0000, psel_pkg::ST_EMPTY},
      '{psel_pkg::OP_LOAD,  16'hFFFF, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_LOAD,  16'h0000, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_LOAD,  16'h8000, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_LOAD,  16'h8000, 7'd127, 1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd1,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd99,  1'b1, 16'hFFFF, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'hFFFF, 7'd127, 1'b1, 16'hFFFF, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd50,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd37,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{OP_UNUSED,          16'hAAAA, 7'h55,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_CLEAR, 16'h5555, 7'h2A,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd64,  1'b1, 16'h0000, psel_pkg::ST_EMPTY},
      '{psel_pkg::OP_LOAD,  16'h1234, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd99,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_LOAD,  16'h5678, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd25,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd24,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_LOAD,  16'h1234, 7'd0,   1'b1, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_QUERY, 16'h0000, 7'd50,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{OP_UNUSED,          16'h0000, 7'h7F,  1'b0, 16'h0000, psel_pkg::ST_OK},
      '{psel_pkg::OP_CLEAR, 16'hFFFF, 7'd0,   1'b0, 16'h0000, psel_pkg::ST_OK}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   psel_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   psel_pkg::rsp_type rsp_data;

   // Idling percentages of the current phase, read by the sender task and by
   // the result side.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // The predictor's copy of the sample set, kept in ascending order, and the
   // results still owed by the block, oldest first.
   logic [psel_pkg::VALUE_W-1:0] held_samples[$];
   psel_pkg::rsp_type            awaited_results[$];
   psel_pkg::rsp_type            oldest_result;

   bit          mismatch_seen = 1'b0;
   int unsigned quiet_cycles = 0;

   percentile_select_core #(
      .MAX_SAMPLES(SET_DEPTH),
      .SAMPLE_BITS(psel_pkg::VALUE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out what one accepted request does to the set and the result it
   // causes, if any. A load inserts after any equal samples already held. A
   // query picks rank (count*p + 50)/100, clamped to the last entry.
   function automatic bit predict_percentile(input psel_pkg::req_type item,
                                             output psel_pkg::rsp_type res);
      int unsigned slot;
      int unsigned rank;
      res = '0;
      case (item.opcode)
         psel_pkg::OP_CLEAR: begin
            held_samples.delete();
            return 1'b0;
         end
         psel_pkg::OP_LOAD: begin
            if (held_samples.size() >= SET_DEPTH) begin
               res.status = psel_pkg::ST_FULL;
            end else begin
               slot = 0;
               while (slot < held_samples.size() && held_samples[slot] <= item.sample)
                  slot++;
               held_samples.insert(slot, item.sample);
               res.status = psel_pkg::ST_OK;
            end
            return 1'b1;
         end
         psel_pkg::OP_QUERY: begin
            if (held_samples.size() == 0) begin
               res.status = psel_pkg::ST_EMPTY;
            end else begin
               rank = (held_samples.size() * item.percent + psel_pkg::PCT_HALF)
                      / psel_pkg::PCT_SCALE;
               if (rank >= held_samples.size())
                  rank = held_samples.size() - 1;
               res.value  = held_samples[rank];
               res.status = psel_pkg::ST_OK;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Samples lean toward the extremes and a small pool of repeated values, so
   // that equal samples and ties in rank show up often.
   function automatic logic [psel_pkg::VALUE_W-1:0] pick_sample();
      case ($urandom_range(5))
         0: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
         1: return 16'($urandom_range(4)) << 8;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly the nominal 1..99, sometimes anything the 7-bit field can carry.
   function automatic logic [psel_pkg::PERCENT_W-1:0] pick_percent();
      if ($urandom_range(9) == 0)
         return 7'($urandom_range(127));
      return 7'($urandom_range(99, 1));
   endfunction

   // Presents one request and holds it until the block takes it. Valid stays
   // high across back-to-back transfers; it only drops when the sender idles.
   // At the edge of the transfer the expectation, if any, is queued.
   task automatic send_request(input psel_pkg::req_type item, input bit typed,
                               input psel_pkg::rsp_type typed_rsp);
      psel_pkg::rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (predict_percentile(item, res)) begin
         if (typed)
            res = typed_rsp;
         awaited_results.insert(awaited_results.size(), res);
      end
   endtask

   // One phase of random traffic: short sets built by loads between clears,
   // queries spread over them (empty-set queries come right after a clear),
   // and a little noise from the ignored opcode, which is not counted.
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned n_items);
      int unsigned       done_items;
      int unsigned       roll;
      psel_pkg::req_type item;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      done_items = 0;
      while (done_items < n_items) begin
         roll = $urandom_range(99);
         item.sample  = pick_sample();
         item.percent = pick_percent();
         if (roll < 7)
            item.opcode = psel_pkg::OP_CLEAR;
         else if (roll < 10)
            item.opcode = OP_UNUSED;
         else if (roll < 55)
            item.opcode = psel_pkg::OP_LOAD;
         else
            item.opcode = psel_pkg::OP_QUERY;
         send_request(item, 1'b0, '0);
         if (item.opcode != OP_UNUSED)
            done_items++;
      end
   endtask

   // Fills the set to capacity and a few loads beyond, so the full status and
   // ranks near the top of a full set are reached.
   task automatic fill_to_capacity();
      psel_pkg::req_type item;
      int unsigned       n;
      item = '0;
      item.opcode = psel_pkg::OP_CLEAR;
      send_request(item, 1'b0, '0);
      for (n = 0; n < SET_DEPTH + 4; n++) begin
         item.opcode  = psel_pkg::OP_LOAD;
         item.sample  = pick_sample();
         item.percent = pick_percent();
         send_request(item, 1'b0, '0);
         if ($urandom_range(15) == 0) begin
            item.opcode = psel_pkg::OP_QUERY;
            send_request(item, 1'b0, '0);
         end
      end
      repeat (12) begin
         item.opcode  = psel_pkg::OP_QUERY;
         item.percent = pick_percent();
         send_request(item, 1'b0, '0);
      end
   endtask

   // Result side: a transfer happens at an edge where valid is high and the
   // stall driven at the previous edge is low. The stall for the next cycle
   // is then drawn for the current phase.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result with none expected: value %h status %0d",
                   rsp_data.value, rsp_data.status);
            mismatch_seen = 1'b1;
         end else begin
            oldest_result = awaited_results.pop_front();
            if (rsp_data.value !== oldest_result.value) begin
               $error("value: expected %h, got %h", oldest_result.value, rsp_data.value);
               mismatch_seen = 1'b1;
            end
            if (rsp_data.status !== oldest_result.status) begin
               $error("status: expected %0d, got %0d", oldest_result.status, rsp_data.status);
               mismatch_seen = 1'b1;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: any stretch this long with no transfer on either side is a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      psel_pkg::req_type row_req;
      psel_pkg::rsp_type row_rsp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, no idling on either side.
      foreach (directed_rows[i]) begin
         row_req.opcode  = directed_rows[i].opcode;
         row_req.sample  = directed_rows[i].sample;
         row_req.percent = directed_rows[i].percent;
         row_rsp.value   = directed_rows[i].want_value;
         row_rsp.status  = directed_rows[i].want_status;
         send_request(row_req, directed_rows[i].typed, row_rsp);
      end

      // Random traffic over the idling phases, with one run up to a full set.
      run_phase(0, 0, 110);
      run_phase(72, 0, 110);
      run_phase(0, 72, 110);
      run_phase(19, 19, 110);
      fill_to_capacity();
      run_phase(0, 0, 40);

      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (!mismatch_seen)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
